>>> rtl/sfcap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcap_pkg
// Shared types and constants of the sync frame checksum attitude parser.
// ----------------------------------------------------------------------------
package sfcap_pkg;

	localparam logic [7:0] SyncFirst  = 8'hAA;
	localparam logic [7:0] SyncSecond = 8'h55;

	// Frame layout: header 0..1, checksummed body 2..10, checksum at 11
	localparam logic [3:0] PosFirst   = 4'd0;
	localparam logic [3:0] SumFirst   = 4'd2;
	localparam logic [3:0] AttFirst   = 4'd5;
	localparam logic [3:0] AttLast    = 4'd10;
	localparam logic [3:0] SumByte    = 4'd11;

	localparam int unsigned AttBytes  = 6;
	localparam int unsigned AttIdxW   = $clog2(AttBytes);

	typedef struct packed {
		logic        [15:0] yaw_hundredths;
		logic signed [15:0] pitch_hundredths;
		logic signed [15:0] roll_hundredths;
	} att_t;

endpackage

>>> rtl/sfcap_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcap channel interfaces
// Byte input channel and attitude result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfcap_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfcap_att_if;
	logic               valid;
	logic               ready;
	logic        [15:0] yaw_hundredths;
	logic signed [15:0] pitch_hundredths;
	logic signed [15:0] roll_hundredths;

	modport source (output valid, output yaw_hundredths, output pitch_hundredths,
		output roll_hundredths, input ready);
	modport sink   (input valid, input yaw_hundredths, input pitch_hundredths,
		input roll_hundredths, output ready);
endinterface

>>> rtl/sync_frame_checksum_attitude_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_frame_checksum_attitude_parser
// Parses 12-byte AA 55 framed sensor records and returns raw attitude.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle, every cycle, while the two-entry
// result buffer has room; each byte is handled in the cycle it is accepted
// by the position counter, a running 8-bit checksum and the capture of
// bytes 5 to 10. A byte 0x55 after 0xAA restarts the frame at position 2.
// When the twelfth byte arrives and the wrapping sum of bytes 2 to 10 matches
// it, one result (yaw unsigned, pitch and roll signed, all little-endian, in
// raw hundredths of a degree) enters the buffer and is offered on the next
// cycle if the buffer held none; a mismatching frame gives no result. Input
// ready drops only while both buffer entries hold results not yet taken.
module sync_frame_checksum_attitude_parser
	import sfcap_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sfcap_byte_if.sink  rx,
	sfcap_att_if.source att
);

	logic acc;
	logic emit;
	logic full;
	att_t frame_att;

	assign rx.ready = !full;
	assign acc      = rx.valid && rx.ready;

	sfcap_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.rx_byte (rx.rx_byte),
		.emit    (emit),
		.att     (frame_att)
	);

	sfcap_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (frame_att),
		.full      (full),
		.att       (att)
	);

endmodule

>>> rtl/sfcap_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcap_parse
// Frame position tracking, resync detection, running checksum and capture
// of the attitude bytes. Flags a finished, checksum-clean frame in the
// cycle its checksum byte is accepted.
// ----------------------------------------------------------------------------
module sfcap_parse
	import sfcap_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  logic [7:0] rx_byte,
	output logic       emit,
	output att_t       att
);

	logic [3:0]         pos_q;
	logic [7:0]         prev_q;
	logic [7:0]         sum_q;
	logic [7:0]         store_q [AttBytes];
	logic               resync;
	logic [3:0]         pos_nxt;
	logic [AttIdxW-1:0] att_idx;
	logic               att_hit;

	assign resync  = (rx_byte == SyncSecond) && (prev_q == SyncFirst);
	assign att_hit = (pos_q >= AttFirst) && (pos_q <= AttLast);
	assign att_idx = AttIdxW'(pos_q - AttFirst);

	always_comb begin
		if (resync) begin
			pos_nxt = SumFirst;
		end else if (pos_q == SumByte) begin
			pos_nxt = PosFirst;
		end else if (pos_q > SumByte) begin
			// unreachable; treat as position zero, then advance
			pos_nxt = PosFirst + 4'd1;
		end else begin
			pos_nxt = pos_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= PosFirst;
			prev_q <= '0;
			sum_q  <= '0;
		end else if (acc) begin
			pos_q  <= pos_nxt;
			prev_q <= rx_byte;
			// restart the sum on the first body byte
			sum_q  <= (pos_q == SumFirst) ? rx_byte : sum_q + rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && att_hit) begin
			store_q[att_idx] <= rx_byte;
		end
	end

	assign emit = acc && !resync && (pos_q == SumByte) && (sum_q == rx_byte);

	assign att.yaw_hundredths   = {store_q[1], store_q[0]};
	assign att.pitch_hundredths = {store_q[3], store_q[2]};
	assign att.roll_hundredths  = {store_q[5], store_q[4]};

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= SumByte)
		else $error("frame position out of range");

	a_resync_pos: assert property (@(posedge clk) disable iff (!arst_n)
		acc && resync |=> pos_q == SumFirst)
		else $error("resync did not move position to first body byte");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !resync && pos_q < SumByte |=> pos_q == $past(pos_q) + 4'd1)
		else $error("position did not advance");

	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> pos_q == PosFirst)
		else $error("result emitted without frame wrap");

endmodule

>>> rtl/sfcap_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcap_outbuf
// Two-entry result buffer. Decouples the result channel from the byte
// channel so bytes keep flowing while a result waits to be taken.
// ----------------------------------------------------------------------------
module sfcap_outbuf
	import sfcap_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  att_t        push_data,
	output logic        full,
	sfcap_att_if.source att
);

	att_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop       = att.valid && att.ready;
	assign full      = (cnt_q == 2'd2);
	assign att.valid = (cnt_q != 2'd0);

	assign att.yaw_hundredths   = mem_q[rd_q].yaw_hundredths;
	assign att.pitch_hundredths = mem_q[rd_q].pitch_hundredths;
	assign att.roll_hundredths  = mem_q[rd_q].roll_hundredths;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("result pushed into full buffer");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("buffer count out of range");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wr_q != rd_q))
		else $error("buffer pointers disagree with count");

endmodule
